// ===== sv/slcfp_pkg.sv =====
package slcfp_pkg;

	localparam int BYTE_W  = 8;
	localparam int ANGLE_W = 32;

	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;

	typedef enum logic [2:0] {
		PH_HUNT1   = 3'd0,
		PH_HUNT2   = 3'd1,
		PH_ID      = 3'd2,
		PH_LEN     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CHECK   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_GOOD  = 2'd0,
		ST_BAD   = 2'd1,
		ST_SHORT = 2'd2
	} status_t;

endpackage

// ===== sv/slcfp_rx_if.sv =====
interface slcfp_rx_if;
	logic                          valid;
	logic                          ready;
	logic [slcfp_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/slcfp_res_if.sv =====
interface slcfp_res_if;
	logic                                 valid;
	logic                                 ready;
	slcfp_pkg::status_t                   status;
	logic signed [slcfp_pkg::ANGLE_W-1:0] angle;
	logic [slcfp_pkg::BYTE_W-1:0]         frame_id;
	logic [slcfp_pkg::BYTE_W-1:0]         payload_len;

	modport source (output valid, output status, output angle, output frame_id,
		output payload_len, input ready);
	modport sink   (input valid, input status, input angle, input frame_id,
		input payload_len, output ready);
endinterface

// ===== sv/sync_length_checksum_frame_parser.sv =====
// Serial frame parser: header, header, id, length, payload, checksum.
// rx channel: one received byte per beat (valid/ready).
// res channel: one beat per frame, issued when the checksum byte is
//   processed; carries status, frame_id, payload_len and the big-endian
//   signed angle from the first four payload bytes.
// cfg_we/cfg_data: write the sync byte; write only while the parser is idle.
// Result path: a checksum byte, once taken, waits in the input register,
//   then the result register loads.
// Throughput: one byte per cycle, set by the single-pass state update
//   between the input register and the result register, unless stalled.
// Stall: while an undelivered result sits in the result register and the
//   receiver holds ready low, the input register holds its byte and rx
//   ready drops once it is full; nothing is lost or repeated.
// Reset (arst_n low): parser returns to hunting the first header byte,
//   sums and counters clear, sync byte returns to 0xAA, no beats pending.
module sync_length_checksum_frame_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [slcfp_pkg::BYTE_W-1:0] cfg_data,
	slcfp_rx_if.sink                      rx,
	slcfp_res_if.source                   res
);
	import slcfp_pkg::*;

	logic [BYTE_W-1:0]  header_q;
	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;

	phase_t             phase_q, phase_d;
	logic [BYTE_W-1:0]  sum_q, sum_d;
	logic [BYTE_W-1:0]  len_q, len_d;
	logic [BYTE_W-1:0]  seen_q, seen_d;
	logic [ANGLE_W-1:0] angle_q, angle_d;
	logic [BYTE_W-1:0]  id_q, id_d;

	logic               res_valid_q;
	status_t            res_status_q, status_d;
	logic [ANGLE_W-1:0] res_angle_q, res_angle_d;
	logic [BYTE_W-1:0]  res_id_q;
	logic [BYTE_W-1:0]  res_len_q;

	logic               advance;
	logic               emit;
	logic               good;
	logic [BYTE_W-1:0]  seen_inc;

	assign advance  = valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (cfg_we) begin
			header_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign seen_inc = seen_q + 8'd1;
	assign good     = (byte_s1 == sum_q);

	always_comb begin
		phase_d     = phase_q;
		sum_d       = sum_q;
		len_d       = len_q;
		seen_d      = seen_q;
		angle_d     = angle_q;
		id_d        = id_q;
		emit        = 1'b0;
		status_d    = ST_GOOD;
		res_angle_d = '0;
		unique case (phase_q)
			PH_HUNT2: begin
				if (byte_s1 == header_q) begin
					phase_d = PH_ID;
					sum_d   = header_q + header_q;
				end else begin
					phase_d = PH_HUNT1;
				end
			end
			PH_ID: begin
				id_d    = byte_s1;
				sum_d   = sum_q + byte_s1;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d   = byte_s1;
				sum_d   = sum_q + byte_s1;
				seen_d  = '0;
				angle_d = '0;
				phase_d = (byte_s1 == '0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				sum_d = sum_q + byte_s1;
				if (seen_q < 8'd4) begin
					case (seen_q[1:0])
						2'd0:    angle_d[31:24] = byte_s1;
						2'd1:    angle_d[23:16] = byte_s1;
						2'd2:    angle_d[15:8]  = byte_s1;
						default: angle_d[7:0]   = byte_s1;
					endcase
				end
				seen_d = seen_inc;
				if (seen_inc >= len_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				emit = 1'b1;
				if (!good) begin
					status_d = ST_BAD;
				end else if (len_q < 8'd4) begin
					status_d = ST_SHORT;
				end else begin
					status_d = ST_GOOD;
				end
				res_angle_d = good ? angle_q : '0;
				phase_d     = PH_HUNT1;
			end
			default: begin
				phase_d = (byte_s1 == header_q) ? PH_HUNT2 : PH_HUNT1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			sum_q   <= '0;
			len_q   <= '0;
			seen_q  <= '0;
			angle_q <= '0;
			id_q    <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			len_q   <= len_d;
			seen_q  <= seen_d;
			angle_q <= angle_d;
			id_q    <= id_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_status_q <= status_d;
			res_angle_q  <= res_angle_d;
			res_id_q     <= id_q;
			res_len_q    <= len_q;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.status      = res_status_q;
	assign res.angle       = res_angle_q;
	assign res.frame_id    = res_id_q;
	assign res.payload_len = res_len_q;

endmodule
